[rtl/core/rdfs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row distance fog shader package
// Word types, register codes and fixed widths shared by the shader pipeline.
// ----------------------------------------------------------------------------
package rdfs_pkg;

   // field widths of the request and response words
   localparam int ROW_W      = 12;
   localparam int CHAN_W     = 8;
   localparam int COLOR_W    = 24;

   // register widths
   localparam int IMG_H_W    = 13;
   localparam int EYE_W      = 21;
   localparam int SCALE_W    = 16;
   localparam int FADE_K_W   = 24;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 24;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EYE_HEIGHT    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT_SCALE  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FADE_DISTANCE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FLOOR_COLOR   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_CEILING_COLOR = 3'd5;

   // register reset values
   localparam logic [IMG_H_W-1:0]  IMG_H_RESET  = 13'd480;
   localparam logic [EYE_W-1:0]    EYE_RESET    = 21'd0;
   localparam logic [SCALE_W-1:0]  SCALE_RESET  = 16'd4096;
   localparam logic [FADE_K_W-1:0] FADE_K_RESET = 24'd256;
   localparam logic [COLOR_W-1:0]  COLOR_RESET  = 24'd0;

   // datapath widths
   localparam int HS_W       = IMG_H_W + SCALE_W;   // image_height * height_scale
   localparam int EV_W       = EYE_W + 1 + 6;       // +/- eye_height * 64
   localparam int DEN_W      = 14;                  // 2*row - image_height, signed
   localparam int NUM_W      = 32;                  // numerator, signed
   localparam int ANUM_W     = 31;                  // numerator magnitude
   localparam int DIST_DVD_W = 26;                  // magnitude / 32
   localparam int DIST_DVS_W = 13;                  // denominator magnitude
   localparam int DIST_Q_W   = 20;                  // Q12.8 distance
   localparam int SQ_W       = 2 * DIST_Q_W;
   localparam int DSQ_W      = 24;                  // Q16.8 distance squared
   localparam int SUM_W      = FADE_K_W + 1;

   localparam logic [DIST_Q_W-1:0] DIST_MAX = '1;
   localparam logic [DSQ_W-1:0]    DSQ_MAX  = '1;

   // quotient bits resolved per divider stage
   localparam int DIV_STEP   = 3;

   typedef struct packed {
      logic             op;
      logic [ROW_W-1:0] row;
   } req_type;

   typedef struct packed {
      logic [ROW_W-1:0]   row_out;
      logic [COLOR_W-1:0] shaded_color;
   } rsp_type;

   // control carried alongside the arithmetic
   typedef struct packed {
      logic             op;
      logic [ROW_W-1:0] row;
      logic             kill;   // force black
      logic             sat;    // distance saturates
   } side_type;

endpackage

[rtl/core/rdfs_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Resolves STEP quotient bits per register stage; one division enters per
// cycle. The top dividend bits above the quotient must be below the divisor.
// ----------------------------------------------------------------------------
module rdfs_div #(
   parameter int DVD_W  = 26,
   parameter int DVS_W  = 13,
   parameter int QUO_W  = 20,
   parameter int STEP   = 3,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [DVD_W-1:0]  in_dividend,
   input  logic [DVS_W-1:0]  in_divisor,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [QUO_W-1:0]  out_quotient,
   output logic [SIDE_W-1:0] out_side
);

   localparam int STAGES = (QUO_W + STEP - 1) / STEP;

   // stage boundaries: index s feeds stage s, index STAGES is the result
   logic              valid_b [STAGES+1];
   logic [DVS_W-1:0]  rem_b   [STAGES+1];
   logic [QUO_W-1:0]  bits_b  [STAGES+1];
   logic [QUO_W-1:0]  quo_b   [STAGES+1];
   logic [DVS_W-1:0]  dvs_b   [STAGES+1];
   logic [SIDE_W-1:0] side_b  [STAGES+1];

   assign valid_b[0] = in_valid;
   assign rem_b[0]   = DVS_W'(in_dividend[DVD_W-1:QUO_W]);
   assign bits_b[0]  = in_dividend[QUO_W-1:0];
   assign quo_b[0]   = '0;
   assign dvs_b[0]   = in_divisor;
   assign side_b[0]  = in_side;

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic              valid_ff;
      logic [DVS_W-1:0]  rem_ff, rem_in;
      logic [QUO_W-1:0]  bits_ff, bits_in;
      logic [QUO_W-1:0]  quo_ff, quo_in;
      logic [DVS_W-1:0]  dvs_ff;
      logic [SIDE_W-1:0] side_ff;

      always_comb begin
         logic [DVS_W:0]   trial;
         logic [DVS_W-1:0] rem;
         logic [QUO_W-1:0] bits;
         logic [QUO_W-1:0] quo;
         rem   = rem_b[s];
         bits  = bits_b[s];
         quo   = quo_b[s];
         trial = '0;
         for (int j = 0; j < STEP; j++) begin
            if (s * STEP + j < QUO_W) begin
               trial = {rem, bits[QUO_W-1]};
               if (trial >= {1'b0, dvs_b[s]}) begin
                  rem = DVS_W'(trial - {1'b0, dvs_b[s]});
                  quo = {quo[QUO_W-2:0], 1'b1};
               end else begin
                  rem = trial[DVS_W-1:0];
                  quo = {quo[QUO_W-2:0], 1'b0};
               end
               bits = {bits[QUO_W-2:0], 1'b0};
            end
         end
         rem_in  = rem;
         bits_in = bits;
         quo_in  = quo;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else begin
            valid_ff <= valid_b[s];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff  <= rem_in;
         bits_ff <= bits_in;
         quo_ff  <= quo_in;
         dvs_ff  <= dvs_b[s];
         side_ff <= side_b[s];
      end

      assign valid_b[s+1] = valid_ff;
      assign rem_b[s+1]   = rem_ff;
      assign bits_b[s+1]  = bits_ff;
      assign quo_b[s+1]   = quo_ff;
      assign dvs_b[s+1]   = dvs_ff;
      assign side_b[s+1]  = side_ff;
   end

   assign out_valid    = valid_b[STAGES];
   assign out_quotient = quo_b[STAGES];
   assign out_side     = side_b[STAGES];

endmodule

[rtl/core/rdfs_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shader front end
// Forms the distance numerator and denominator of a row and their magnitudes
// over four register stages, ready for the distance divider.
// ----------------------------------------------------------------------------
module rdfs_front import rdfs_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  req_type                 in_word,
   input  logic [IMG_H_W-1:0]      image_height,
   input  logic [EYE_W-1:0]        eye_height,
   input  logic [SCALE_W-1:0]      height_scale,
   output logic                    out_valid,
   output logic [DIST_DVD_W-1:0]   out_dividend,
   output logic [DIST_DVS_W-1:0]   out_divisor,
   output side_type                out_side
);

   // stage 1: capture
   logic             v1_ff, op1_ff;
   logic [ROW_W-1:0] row1_ff;

   // stage 2: products
   logic                    v2_ff, op2_ff;
   logic [ROW_W-1:0]        row2_ff;
   logic [HS_W-1:0]         hs2_ff, hs2_in;
   logic signed [EV_W-1:0]  ev2_ff, ev2_in;
   logic signed [DEN_W-1:0] den2_ff, den2_in;

   // stage 3: numerator
   logic                    v3_ff, op3_ff;
   logic [ROW_W-1:0]        row3_ff;
   logic signed [NUM_W-1:0] num3_ff, num3_in;
   logic signed [DEN_W-1:0] den3_ff;

   // stage 4: magnitudes
   logic                  v4_ff;
   logic [DIST_DVD_W-1:0] dvd4_ff;
   logic [DIST_DVS_W-1:0] dvs4_ff;
   side_type              side4_ff, side4_in;
   logic [DIST_DVD_W-1:0] dvd4_in;
   logic [DIST_DVS_W-1:0] dvs4_in;

   always_comb begin
      logic signed [EYE_W:0] eye_ext;
      logic signed [EYE_W:0] eye_sel;
      eye_ext = {eye_height[EYE_W-1], eye_height};
      eye_sel = op1_ff ? -eye_ext : eye_ext;
      ev2_in  = {eye_sel, 6'b0};
      hs2_in  = HS_W'(image_height) * HS_W'(height_scale);
      den2_in = $signed({1'b0, row1_ff, 1'b0}) - $signed({1'b0, image_height});
   end

   assign num3_in = NUM_W'(ev2_ff) - $signed({2'b0, hs2_ff, 1'b0});

   always_comb begin
      logic signed [NUM_W-1:0] num_neg;
      logic signed [DEN_W-1:0] den_neg;
      logic [ANUM_W-1:0]       num_mag;
      num_neg = -num3_ff;
      den_neg = -den3_ff;
      num_mag = num3_ff[NUM_W-1] ? num_neg[ANUM_W-1:0] : num3_ff[ANUM_W-1:0];
      dvd4_in = num_mag[ANUM_W-1:5];
      dvs4_in = den3_ff[DEN_W-1] ? den_neg[DIST_DVS_W-1:0] : den3_ff[DIST_DVS_W-1:0];
      side4_in.op   = op3_ff;
      side4_in.row  = row3_ff;
      side4_in.kill = (den3_ff == '0);
      // quotient would not fit in the distance field
      side4_in.sat  = (DIST_DVS_W'(dvd4_in[DIST_DVD_W-1:DIST_Q_W]) >= dvs4_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      op1_ff   <= in_word.op;
      row1_ff  <= in_word.row;
      op2_ff   <= op1_ff;
      row2_ff  <= row1_ff;
      hs2_ff   <= hs2_in;
      ev2_ff   <= ev2_in;
      den2_ff  <= den2_in;
      op3_ff   <= op2_ff;
      row3_ff  <= row2_ff;
      num3_ff  <= num3_in;
      den3_ff  <= den2_ff;
      dvd4_ff  <= dvd4_in;
      dvs4_ff  <= dvs4_in;
      side4_ff <= side4_in;
   end

   assign out_valid    = v4_ff;
   assign out_dividend = dvd4_ff;
   assign out_divisor  = dvs4_ff;
   assign out_side     = side4_ff;

endmodule

[rtl/core/rdfs_shade.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Color fade stage
// Scales each channel of the chosen base color by the fade factor and
// registers the response word.
// ----------------------------------------------------------------------------
module rdfs_shade import rdfs_pkg::*; #(
   parameter int FADE_FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [FADE_FRAC_BITS:0]   in_fade,
   input  side_type                  in_side,
   input  logic [COLOR_W-1:0]        floor_color,
   input  logic [COLOR_W-1:0]        ceiling_color,
   output logic                      out_valid,
   output rsp_type                   out_word
);

   logic    valid_ff;
   rsp_type word_ff, word_in;

   always_comb begin
      logic [FADE_FRAC_BITS:0]        fade;
      logic [COLOR_W-1:0]             base;
      logic [CHAN_W+FADE_FRAC_BITS:0] prod;
      logic [CHAN_W:0]                chan;
      fade = in_side.kill ? '0 : in_fade;
      base = in_side.op ? floor_color : ceiling_color;
      word_in.row_out = in_side.row;
      word_in.shaded_color = '0;
      for (int c = 0; c < COLOR_W / CHAN_W; c++) begin
         prod = (CHAN_W + FADE_FRAC_BITS + 1)'(base[c*CHAN_W +: CHAN_W])
              * (CHAN_W + FADE_FRAC_BITS + 1)'(fade);
         chan = prod[CHAN_W+FADE_FRAC_BITS:FADE_FRAC_BITS];
         word_in.shaded_color[c*CHAN_W +: CHAN_W] = chan[CHAN_W] ? '1 : chan[CHAN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

[rtl/core/row_distance_fog_shader.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row distance fog shader
// Shades a ceiling or floor row: apparent distance from the row's offset to
// the horizon, fade K/(K + distance^2), base color scaled by the fade.
// ----------------------------------------------------------------------------
//
//   port group   direction   handshake            word
//   req_         in          start / busy         req_type  {op, row}
//   rsp_         out         rsp_valid strobe     rsp_type  {row_out, shaded_color}
//   csr_         in          csr_we               csr_index, csr_wdata
//
// Cycles: one row enters per clock while reset is not held. The two pipelined
//   dividers, the distance divider and the fade divider, resolve three
//   quotient bits per stage.
// Reset: synchronous; flushes all words in flight and reloads the registers.
//   busy is high only while reset is held.
// Stalls: none. The response is shown for a single cycle and must be taken.
// ----------------------------------------------------------------------------
module row_distance_fog_shader import rdfs_pkg::*; #(
   parameter int ROW_BITS       = 12,
   parameter int FADE_FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_word,
   output logic                   rsp_valid,
   output rsp_type                rsp_word,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // Keep only the low ROW_BITS bits (at most ROW_W) of the requested row.
   localparam int ROW_KEEP = (ROW_BITS < ROW_W) ? ROW_BITS : ROW_W;
   localparam logic [ROW_W-1:0] ROW_MASK = ~({ROW_W{1'b1}} << ROW_KEEP);
   localparam int FADE_Q_W = FADE_FRAC_BITS + 1;      // fade reaches exactly 1.0
   localparam int FADE_DVD_W = FADE_K_W + FADE_FRAC_BITS;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [IMG_H_W-1:0]  image_height_ff;
   logic [EYE_W-1:0]    eye_height_ff;
   logic [SCALE_W-1:0]  height_scale_ff;
   logic [FADE_K_W-1:0] fade_distance_ff;
   logic [COLOR_W-1:0]  floor_color_ff;
   logic [COLOR_W-1:0]  ceiling_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_height_ff  <= IMG_H_RESET;
         eye_height_ff    <= EYE_RESET;
         height_scale_ff  <= SCALE_RESET;
         fade_distance_ff <= FADE_K_RESET;
         floor_color_ff   <= COLOR_RESET;
         ceiling_color_ff <= COLOR_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_HEIGHT:  image_height_ff  <= csr_wdata[IMG_H_W-1:0];
            CSR_EYE_HEIGHT:    eye_height_ff    <= csr_wdata[EYE_W-1:0];
            CSR_HEIGHT_SCALE:  height_scale_ff  <= csr_wdata[SCALE_W-1:0];
            CSR_FADE_DISTANCE: fade_distance_ff <= csr_wdata[FADE_K_W-1:0];
            CSR_FLOOR_COLOR:   floor_color_ff   <= csr_wdata[COLOR_W-1:0];
            CSR_CEILING_COLOR: ceiling_color_ff <= csr_wdata[COLOR_W-1:0];
            default: ;   // drop writes to unused indexes
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Accept: the pipeline never backs up, so hold off only during reset.
   // ---------------------------------------------------------------------
   logic    accept;
   req_type req_masked;

   assign busy   = reset;
   assign accept = start & ~busy;

   always_comb begin
      req_masked     = req_word;
      req_masked.row = req_word.row & ROW_MASK;
   end

   // ---------------------------------------------------------------------
   // Numerator and denominator magnitudes (four stages)
   // ---------------------------------------------------------------------
   logic                  front_valid;
   logic [DIST_DVD_W-1:0] front_dividend;
   logic [DIST_DVS_W-1:0] front_divisor;
   side_type              front_side;

   rdfs_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (accept),
      .in_word      (req_masked),
      .image_height (image_height_ff),
      .eye_height   (eye_height_ff),
      .height_scale (height_scale_ff),
      .out_valid    (front_valid),
      .out_dividend (front_dividend),
      .out_divisor  (front_divisor),
      .out_side     (front_side)
   );

   // ---------------------------------------------------------------------
   // Distance divider: |N|/32 over |D|, 20 quotient bits. Saturated
   // quotients were flagged up front and are replaced below.
   // ---------------------------------------------------------------------
   logic                dist_valid;
   logic [DIST_Q_W-1:0] dist_q;
   side_type            dist_side;

   rdfs_div #(
      .DVD_W  (DIST_DVD_W),
      .DVS_W  (DIST_DVS_W),
      .QUO_W  (DIST_Q_W),
      .STEP   (DIV_STEP),
      .SIDE_W ($bits(side_type))
   ) u_dist_div (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (front_valid),
      .in_dividend  (front_dividend),
      .in_divisor   (front_divisor),
      .in_side      (front_side),
      .out_valid    (dist_valid),
      .out_quotient (dist_q),
      .out_side     (dist_side)
   );

   // ---------------------------------------------------------------------
   // Square stage: distance^2 in Q24.16.
   // ---------------------------------------------------------------------
   logic                sq_valid_ff;
   logic [SQ_W-1:0]     sq_ff, sq_in;
   side_type            sq_side_ff;
   logic [DIST_Q_W-1:0] dist_sel;

   assign dist_sel = dist_side.sat ? DIST_MAX : dist_q;
   assign sq_in    = SQ_W'(dist_sel) * SQ_W'(dist_sel);

   // ---------------------------------------------------------------------
   // Sum stage: K + saturated distance^2 (Q16.8); a zero sum means black.
   // ---------------------------------------------------------------------
   logic             sum_valid_ff;
   logic [SUM_W-1:0] sum_ff, sum_in;
   side_type         sum_side_ff, sum_side_in;
   logic [DSQ_W-1:0] dsq;

   always_comb begin
      dsq  = (|sq_ff[SQ_W-1:DSQ_W+8]) ? DSQ_MAX : sq_ff[DSQ_W+7:8];
      sum_in = {1'b0, fade_distance_ff} + SUM_W'(dsq);
      sum_side_in = sq_side_ff;
      sum_side_in.kill = sq_side_ff.kill | ((fade_distance_ff == '0) && (dsq == '0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff  <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else begin
         sq_valid_ff  <= dist_valid;
         sum_valid_ff <= sq_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff       <= sq_in;
      sq_side_ff  <= dist_side;
      sum_ff      <= sum_in;
      sum_side_ff <= sum_side_in;
   end

   // ---------------------------------------------------------------------
   // Fade divider: K * 2^FADE_FRAC_BITS over the sum, with K fed straight from its
   // register. The user must hold K steady while rows are in flight; not enforced.
   // ---------------------------------------------------------------------
   logic                  fade_valid;
   logic [FADE_Q_W-1:0]   fade_q;
   side_type              fade_side;
   logic [FADE_DVD_W-1:0] fade_dividend;

   assign fade_dividend = {fade_distance_ff, {FADE_FRAC_BITS{1'b0}}};

   rdfs_div #(
      .DVD_W  (FADE_DVD_W),
      .DVS_W  (SUM_W),
      .QUO_W  (FADE_Q_W),
      .STEP   (DIV_STEP),
      .SIDE_W ($bits(side_type))
   ) u_fade_div (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (sum_valid_ff),
      .in_dividend  (fade_dividend),
      .in_divisor   (sum_ff),
      .in_side      (sum_side_ff),
      .out_valid    (fade_valid),
      .out_quotient (fade_q),
      .out_side     (fade_side)
   );

   // ---------------------------------------------------------------------
   // Scale the base color and drive the response word.
   // ---------------------------------------------------------------------
   rdfs_shade #(
      .FADE_FRAC_BITS (FADE_FRAC_BITS)
   ) u_shade (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (fade_valid),
      .in_fade       (fade_q),
      .in_side       (fade_side),
      .floor_color   (floor_color_ff),
      .ceiling_color (ceiling_color_ff),
      .out_valid     (rsp_valid),
      .out_word      (rsp_word)
   );

endmodule

[rtl/core/rdfs_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shader port checker
// Checks fixed latency, one response per request and the echoed row.
// ----------------------------------------------------------------------------
module rdfs_checker import rdfs_pkg::*; #(
   parameter int ROW_BITS       = 12,
   parameter int FADE_FRAC_BITS = 16
) (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_word,
   input logic    rsp_valid,
   input rsp_type rsp_word
);

   localparam int DIST_STAGES = (DIST_Q_W + DIV_STEP - 1) / DIV_STEP;
   localparam int FADE_STAGES = (FADE_FRAC_BITS + 1 + DIV_STEP - 1) / DIV_STEP;
   localparam int LATENCY     = 7 + DIST_STAGES + FADE_STAGES;
   localparam int ROW_KEEP    = (ROW_BITS < ROW_W) ? ROW_BITS : ROW_W;
   localparam logic [ROW_W-1:0] ROW_MASK = ~({ROW_W{1'b1}} << ROW_KEEP);

   logic accept;
   assign accept = start & ~busy;

   // every accepted word comes out after the fixed latency
   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_valid)
      else $error("accepted word produced no response");

   // no response appears without a matching request
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("response without a request");

   // the row travels with its color
   a_row_echo: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.row_out == ($past(req_word.row, LATENCY) & ROW_MASK)))
      else $error("row_out does not match the requested row");

   // a request held during reset is never taken
   a_reset_busy: assert property (@(posedge clock)
      reset |=> (!rsp_valid || !$past(reset, LATENCY)))
      else $error("response from a word offered during reset");

endmodule

bind row_distance_fog_shader rdfs_checker #(
   .ROW_BITS       (ROW_BITS),
   .FADE_FRAC_BITS (FADE_FRAC_BITS)
) u_rdfs_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_word  (rsp_word)
);
